// ===== rtl/umpq_pkg.sv =====
// ----------------------------------------------------------------------------
// Unsorted max priority queue package
// Shared constants, codes and interface types of the priority queue block.
// ----------------------------------------------------------------------------
package umpq_pkg;

   // Storage geometry.
   localparam int Capacity    = 16;
   localparam int ValueWidth  = 32;
   localparam int IndexWidth  = $clog2(Capacity);
   localparam int CountWidth  = $clog2(Capacity + 1);
   localparam int OpWidth     = 2;
   localparam int StatusWidth = 2;

   // Stream word widths, padded up to whole bytes.
   localparam int ReqBits     = OpWidth + ValueWidth;
   localparam int ReqWidth    = ((ReqBits + 7) / 8) * 8;
   localparam int RspBits     = StatusWidth + ValueWidth + 1 + CountWidth + 1;
   localparam int RspWidth    = ((RspBits + 7) / 8) * 8;

   // Operation codes; the fourth code is a no-operation.
   typedef enum logic [OpWidth-1:0] {
      OP_INSERT   = 2'd0,
      OP_REMOVE   = 2'd1,
      OP_CONTAINS = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   // Result status codes.
   typedef enum logic [StatusWidth-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // Engine sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // One command handed to the engine.
   typedef struct packed {
      op_type                 op;
      logic [ValueWidth-1:0]  value;
   } cmd_type;

   // One result handed back by the engine.
   typedef struct packed {
      logic                   is_empty;
      logic [CountWidth-1:0]  entry_count;
      logic                   found;
      logic [ValueWidth-1:0]  removed_value;
      status_type             status;
   } result_type;

endpackage

// ===== rtl/umpq_engine.sv =====
// ----------------------------------------------------------------------------
// Priority queue engine
// Entry store, entry count and a small sequencer that scans the store one
// entry per cycle through a single shared comparator.
// ----------------------------------------------------------------------------
module umpq_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   output logic                 cmd_ready,
   input  umpq_pkg::cmd_type    cmd,
   output logic                 res_valid,
   input  logic                 res_ready,
   output umpq_pkg::result_type res
);

   localparam int VW = umpq_pkg::ValueWidth;
   localparam int IW = umpq_pkg::IndexWidth;
   localparam int CW = umpq_pkg::CountWidth;

   // Entry store; read data is registered.
   logic [VW-1:0] mem [umpq_pkg::Capacity];

   umpq_pkg::state_type  state_ff, state_in;
   umpq_pkg::op_type     op_ff, op_in;
   umpq_pkg::status_type status_ff, status_in;
   logic [VW-1:0]        value_ff, value_in;
   logic [VW-1:0]        best_ff, best_in;
   logic [VW-1:0]        removed_ff, removed_in;
   logic [VW-1:0]        rd_data_ff;
   logic [IW-1:0]        idx_ff, idx_in;
   logic [IW-1:0]        best_idx_ff, best_idx_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 found_ff, found_in;

   logic [IW-1:0]        rd_addr;
   logic                 wr_en;
   logic [IW-1:0]        wr_addr;
   logic [VW-1:0]        wr_data;

   logic [VW-1:0]        cmp_operand;
   logic                 cmp_gt;
   logic                 cmp_eq;
   logic                 take;
   logic                 last;
   logic [IW-1:0]        cur_best_idx;
   logic [VW-1:0]        cur_best;

   // Shared comparator: against the running best on remove, the key on contains.
   always_comb begin
      cmp_operand = (op_ff == umpq_pkg::OP_REMOVE) ? best_ff : value_ff;
      cmp_gt      = $signed(rd_data_ff) > $signed(cmp_operand);
      cmp_eq      = rd_data_ff == cmp_operand;
   end

   // Scan bookkeeping: the first entry seeds the best, a later one wins only if greater.
   always_comb begin
      take         = (idx_ff == '0) || cmp_gt;
      cur_best_idx = take ? idx_ff : best_idx_ff;
      cur_best     = take ? rd_data_ff : best_ff;
      last         = {1'b0, idx_ff} == (count_ff - CW'(1));
   end

   // Sequencer: next state, datapath updates and store access.
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      status_in   = status_ff;
      value_in    = value_ff;
      best_in     = best_ff;
      removed_in  = removed_ff;
      idx_in      = idx_ff;
      best_idx_in = best_idx_ff;
      count_in    = count_ff;
      found_in    = found_ff;
      rd_addr     = '0;
      wr_en       = 1'b0;
      wr_addr     = count_ff[IW-1:0];
      wr_data     = cmd.value;
      cmd_ready   = 1'b0;
      res_valid   = 1'b0;

      unique case (state_ff)
         umpq_pkg::ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               op_in      = cmd.op;
               value_in   = cmd.value;
               status_in  = umpq_pkg::STATUS_OK;
               removed_in = '0;
               found_in   = 1'b0;
               idx_in     = '0;
               state_in   = umpq_pkg::ST_DONE;
               case (cmd.op)
                  umpq_pkg::OP_INSERT: begin
                     if (count_ff >= CW'(umpq_pkg::Capacity)) begin
                        status_in = umpq_pkg::STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  umpq_pkg::OP_REMOVE: begin
                     if (count_ff == '0) begin
                        status_in = umpq_pkg::STATUS_EMPTY;
                     end else begin
                        state_in = umpq_pkg::ST_SCAN;
                     end
                  end
                  umpq_pkg::OP_CONTAINS: begin
                     if (count_ff != '0) begin
                        state_in = umpq_pkg::ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         umpq_pkg::ST_SCAN: begin
            // Read data holds the entry at idx_ff; fetch the next one meanwhile.
            rd_addr = idx_ff + IW'(1);
            idx_in  = idx_ff + IW'(1);
            if (op_ff == umpq_pkg::OP_REMOVE) begin
               best_in     = cur_best;
               best_idx_in = cur_best_idx;
            end else begin
               found_in = found_ff | cmp_eq;
            end
            if (last) begin
               state_in = umpq_pkg::ST_DONE;
               if (op_ff == umpq_pkg::OP_REMOVE) begin
                  // The last entry is in hand: move it into the freed slot.
                  wr_en      = 1'b1;
                  wr_addr    = cur_best_idx;
                  wr_data    = rd_data_ff;
                  removed_in = cur_best;
                  count_in   = count_ff - CW'(1);
               end
            end
         end

         umpq_pkg::ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = umpq_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = umpq_pkg::ST_IDLE;
         end
      endcase
   end

   // Result word.
   always_comb begin
      res.status        = status_ff;
      res.removed_value = removed_ff;
      res.found         = found_ff;
      res.entry_count   = count_ff;
      res.is_empty      = count_ff == '0;
   end

   // Store write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= umpq_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      status_ff   <= status_in;
      value_ff    <= value_in;
      best_ff     <= best_in;
      removed_ff  <= removed_in;
      idx_ff      <= idx_in;
      best_idx_ff <= best_idx_in;
      found_ff    <= found_in;
   end

endmodule

// ===== rtl/unsorted_max_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// Unsorted max priority queue
// Stream wrapper around the priority queue engine with a registered result.
// ----------------------------------------------------------------------------
// Each request word carries an operation and a signed value: insert the value,
// remove the greatest stored value, or ask whether the value is stored. Every
// request yields exactly one response word with a status, the removed value,
// the found flag, the entry count and an empty flag.
// Insert, refused operations and the no-operation code go from the idle state
// straight to the done state; remove and contains on a non-empty store first
// pass through a scan state over the N stored entries, at most 16, since the
// engine reads the entry store one entry per cycle through one comparator.
// req_tready is high only while the engine is idle.
// The response sits in an output register, so the engine may take and process
// the next request while a response still waits; when the receiver stalls,
// the engine holds its finished result until the register frees up.
// Reset empties the queue and clears both valid signals; stored entries are
// not cleared and are never used before they are written.
// ----------------------------------------------------------------------------
module unsorted_max_priority_queue_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // op [1:0], value [33:2], zero fill above
   input  logic [umpq_pkg::ReqWidth-1:0]   req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status [1:0], removed_value [33:2], found [34], entry_count [39:35],
   // is_empty [40], zero fill above
   output logic [umpq_pkg::RspWidth-1:0]   rsp_tdata
);

   umpq_pkg::cmd_type    cmd;
   umpq_pkg::result_type res;
   logic                 res_valid;
   logic                 res_ready;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   umpq_pkg::result_type rsp_data_ff, rsp_data_in;

   // Unpack the request word.
   always_comb begin
      cmd.op    = umpq_pkg::op_type'(req_tdata[umpq_pkg::OpWidth-1:0]);
      cmd.value = req_tdata[umpq_pkg::ReqBits-1:umpq_pkg::OpWidth];
   end

   umpq_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (req_tvalid),
      .cmd_ready (req_tready),
      .cmd       (cmd),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // Output register loads when empty or being drained.
   always_comb begin
      res_ready     = !rsp_tvalid_ff || rsp_tready;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_data_in   = rsp_data_ff;
      if (res_ready) begin
         rsp_tvalid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(umpq_pkg::RspWidth - umpq_pkg::RspBits){1'b0}}, rsp_data_ff};

endmodule

// ===== verif/tb_unsorted_max_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// Priority queue block testbench
// Streams insert, remove and contains words into the queue and checks every
// response against a behavioral copy of the unsorted store kept in this file.
// ----------------------------------------------------------------------------
// A short directed list comes first: empty remove and contains, the unused op
// code, extreme values, equal greatest values and an insert into a full store.
// Random words follow in fill and drain phases, so the entry count sweeps
// between empty and full many times. Both sides stall at random, except for
// a calm stretch in the middle of the run.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_unsorted_max_priority_queue_top;

   localparam int IdlePercent = 29;
   localparam int RandomWords = 450;
   localparam int CalmFirst   = 180;
   localparam int CalmLast    = 280;
   localparam int StallLimit  = 2000;
   localparam int DrainCycles = 40;
   localparam int ReportLimit = 10;
   localparam int RecentDepth = 8;
   localparam int VW          = umpq_pkg::ValueWidth;

   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [umpq_pkg::ReqWidth-1:0] req_tdata  = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [umpq_pkg::RspWidth-1:0] rsp_tdata;

   // Words waiting to be sent and responses still owed by the block.
   umpq_pkg::cmd_type    request_backlog[$];
   umpq_pkg::result_type awaited_answers[$];

   // Shadow copy of the queue contents.
   logic [VW-1:0] shadow_slots [umpq_pkg::Capacity];
   int            shadow_fill = 0;

   // Recently inserted values, reused so that contains queries hit.
   logic [VW-1:0] recent_values [RecentDepth] = '{default: '0};
   int            recent_next = 0;

   int   mismatch_count = 0;
   int   words_accepted = 0;
   int   stall_cycles   = 0;
   logic calm;

   assign calm = (words_accepted >= CalmFirst) && (words_accepted < CalmLast);

   always begin
      #10 clock = 1'b1;
      #10 clock = 0;
   end

   unsorted_max_priority_queue_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Applies one operation to the shadow queue and returns the response it owes.
   function automatic umpq_pkg::result_type predict_queue_op(input umpq_pkg::op_type op,
                                                             input logic [VW-1:0] value);
      umpq_pkg::result_type answer;
      int                   best;
      int                   i;
      answer        = '0;
      answer.status = umpq_pkg::STATUS_OK;
      case (op)
         umpq_pkg::OP_INSERT: begin
            if (shadow_fill >= umpq_pkg::Capacity) begin
               answer.status = umpq_pkg::STATUS_FULL;
            end else begin
               shadow_slots[shadow_fill] = value;
               shadow_fill++;
            end
         end
         umpq_pkg::OP_REMOVE: begin
            if (shadow_fill == 0) begin
               answer.status = umpq_pkg::STATUS_EMPTY;
            end else begin
               // Strict compare keeps the lowest slot among equal greatest values.
               best = 0;
               for (i = 1; i < shadow_fill; i++) begin
                  if ($signed(shadow_slots[i]) > $signed(shadow_slots[best])) best = i;
               end
               answer.removed_value = shadow_slots[best];
               shadow_fill--;
               shadow_slots[best] = shadow_slots[shadow_fill];
            end
         end
         umpq_pkg::OP_CONTAINS: begin
            for (i = 0; i < shadow_fill; i++) begin
               if (shadow_slots[i] == value) answer.found = 1'b1;
            end
         end
         default: begin
         end
      endcase
      answer.entry_count = umpq_pkg::CountWidth'(shadow_fill);
      answer.is_empty    = (shadow_fill == 0);
      return answer;
   endfunction

   // Appends one word to the backlog and remembers inserted values.
   function automatic void queue_request(input umpq_pkg::op_type op,
                                         input logic [VW-1:0] value);
      request_backlog.push_back(umpq_pkg::cmd_type'{op: op, value: value});
      if (op == umpq_pkg::OP_INSERT) begin
         recent_values[recent_next] = value;
         recent_next = (recent_next + 1) % RecentDepth;
      end
   endfunction

   // Mix of full-range, small, extreme and recently inserted values.
   function automatic logic [VW-1:0] pick_value();
      case ($urandom_range(9))
         0, 1, 2, 3: return $urandom;
         4, 5, 6:    return VW'(int'($urandom_range(8)) - 4);
         7: begin
            if ($urandom_range(1) == 0) return {1'b0, {(VW-1){1'b1}}};
            return {1'b1, {(VW-1){1'b0}}};
         end
         default:    return recent_values[$urandom_range(RecentDepth-1)];
      endcase
   endfunction

   // Stimulus plan, reset and end of run.
   initial begin
      int               plan_fill;
      bit               filling;
      int               roll;
      int               k;
      umpq_pkg::op_type op;

      // Empty queue, unused code and extreme values.
      queue_request(umpq_pkg::OP_REMOVE, '0);
      queue_request(umpq_pkg::OP_CONTAINS, '0);
      queue_request(umpq_pkg::OP_NONE, 32'hFFFF_FFFF);
      queue_request(umpq_pkg::OP_INSERT, 32'h7FFF_FFFF);
      queue_request(umpq_pkg::OP_INSERT, 32'h8000_0000);
      queue_request(umpq_pkg::OP_INSERT, 32'h0000_0000);
      queue_request(umpq_pkg::OP_INSERT, 32'hFFFF_FFFF);
      queue_request(umpq_pkg::OP_CONTAINS, 32'h8000_0000);
      queue_request(umpq_pkg::OP_CONTAINS, 32'd5);
      queue_request(umpq_pkg::OP_REMOVE, '0);
      // Fill up with several equal greatest values, then overflow.
      for (k = 0; k < 13; k++) begin
         queue_request(umpq_pkg::OP_INSERT, (k % 3 == 0) ? 32'd42 : VW'(k));
      end
      queue_request(umpq_pkg::OP_INSERT, 32'd9);
      queue_request(umpq_pkg::OP_CONTAINS, 32'd42);

      // Random words in alternating fill and drain phases.
      plan_fill = umpq_pkg::Capacity;
      filling   = 1'b0;
      for (k = 0; k < RandomWords; k++) begin
         roll = $urandom_range(99);
         if (filling) begin
            op = (roll < 60) ? umpq_pkg::OP_INSERT : (roll < 80) ? umpq_pkg::OP_REMOVE :
                 (roll < 95) ? umpq_pkg::OP_CONTAINS : umpq_pkg::OP_NONE;
         end else begin
            op = (roll < 60) ? umpq_pkg::OP_REMOVE : (roll < 80) ? umpq_pkg::OP_INSERT :
                 (roll < 95) ? umpq_pkg::OP_CONTAINS : umpq_pkg::OP_NONE;
         end
         queue_request(op, pick_value());
         if (op == umpq_pkg::OP_INSERT && plan_fill < umpq_pkg::Capacity) plan_fill++;
         if (op == umpq_pkg::OP_REMOVE && plan_fill > 0) plan_fill--;
         if (filling && plan_fill == umpq_pkg::Capacity && $urandom_range(2) == 0) begin
            filling = 1'b0;
         end else if (!filling && plan_fill == 0 && $urandom_range(2) == 0) begin
            filling = 1'b1;
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (request_backlog.size() != 0 || req_tvalid || awaited_answers.size() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Request driver: predicts each accepted word and presents the next one.
   always @(posedge clock) begin
      umpq_pkg::cmd_type pending;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            awaited_answers.push_back(
               predict_queue_op(umpq_pkg::op_type'(req_tdata[umpq_pkg::OpWidth-1:0]),
                                req_tdata[umpq_pkg::OpWidth +: VW]));
            words_accepted <= words_accepted + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (request_backlog.size() != 0 && (calm || $urandom_range(99) >= IdlePercent)) begin
               pending = request_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {{(umpq_pkg::ReqWidth-umpq_pkg::ReqBits){1'b0}},
                              pending.value, pending.op};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each accepted word and stalls at random.
   always @(posedge clock) begin
      umpq_pkg::result_type seen;
      umpq_pkg::result_type wanted;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = umpq_pkg::result_type'(rsp_tdata[umpq_pkg::RspBits-1:0]);
            if (awaited_answers.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= ReportLimit) begin
                  $display("Unexpected response word %h with nothing outstanding.", rsp_tdata);
               end
            end else begin
               wanted = awaited_answers.pop_front();
               if (seen.status !== wanted.status || seen.removed_value !== wanted.removed_value ||
                   seen.found !== wanted.found || seen.entry_count !== wanted.entry_count ||
                   seen.is_empty !== wanted.is_empty) begin
                  mismatch_count++;
                  if (mismatch_count <= ReportLimit) begin
                     $display("Mismatch: expected status %0d removed %h found %b count %0d empty %b",
                              wanted.status, wanted.removed_value, wanted.found,
                              wanted.entry_count, wanted.is_empty);
                     $display("          actual   status %0d removed %h found %b count %0d empty %b",
                              seen.status, seen.removed_value, seen.found,
                              seen.entry_count, seen.is_empty);
                  end
               end
            end
         end
         rsp_tready <= calm || ($urandom_range(99) >= IdlePercent);
      end
   end

   // Watchdog: ends the run when no word moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles == StallLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

endmodule

// ===== files.f =====
rtl/umpq_pkg.sv
rtl/umpq_engine.sv
rtl/unsorted_max_priority_queue_top.sv
verif/tb_unsorted_max_priority_queue_top.sv
